// ===== hdl/rmq_pkg.sv =====
// rmq_pkg: types, constants and the sat16 saturation helper for rotation_matrix_to_quaternion.
// No dependencies.
`default_nettype none
package rmq_pkg;
  localparam int unsigned FracBitsDef = 14;
  localparam int unsigned FracBitsMax = 30;
  localparam int unsigned ElemW = 16;
  // root argument holds ONE plus three elements at the widest fraction
  localparam int unsigned RW = FracBitsMax + 1;
  localparam int unsigned QDepth = 4;

  typedef enum logic [1:0] {
    AxisX = 2'd0,
    AxisY = 2'd1,
    AxisZ = 2'd2,
    AxisW = 2'd3
  } axis_e;

  typedef struct packed {
    logic signed [ElemW-1:0] m00;
    logic signed [ElemW-1:0] m01;
    logic signed [ElemW-1:0] m02;
    logic signed [ElemW-1:0] m10;
    logic signed [ElemW-1:0] m11;
    logic signed [ElemW-1:0] m12;
    logic signed [ElemW-1:0] m20;
    logic signed [ElemW-1:0] m21;
    logic signed [ElemW-1:0] m22;
  } mat_t;

  typedef struct packed {
    logic signed [ElemW-1:0] qx;
    logic signed [ElemW-1:0] qy;
    logic signed [ElemW-1:0] qz;
    logic signed [ElemW-1:0] qw;
    logic                    degenerate;
  } quat_t;

  // Classified item between front and back.
  typedef struct packed {
    logic                degen;
    axis_e               big;
    axis_e               o1;
    axis_e               o2;
    axis_e               o3;
    logic [RW-1:0]       r;
    logic signed [17:0]  d1;
    logic signed [17:0]  d2;
    logic signed [17:0]  d3;
  } cls_t;

  function automatic logic signed [ElemW-1:0] sat16(input logic signed [63:0] v);
    if (v > 64'sd32767) return 16'sh7fff;
    else if (v < -64'sd32768) return 16'sh8000;
    else return v[ElemW-1:0];
  endfunction
endpackage
`default_nettype wire

// ===== hdl/rmq_front.sv =====
// rmq_front: computes trace, picks the branch and axes, root argument and differences.
// Depends on rmq_pkg.
`default_nettype none
module rmq_front #(
  parameter int unsigned FracBits = rmq_pkg::FracBitsDef
) (
  input  var rmq_pkg::mat_t m_i,
  output rmq_pkg::cls_t   c_o
);
  import rmq_pkg::*;
  localparam logic signed [34:0] One = 35'sd1 <<< FracBits;
  logic signed [34:0] a00, a11, a22, tr, rr, dii, djj, dkk;
  logic [1:0] ai;
  always_comb begin
    a00 = 35'(m_i.m00);
    a11 = 35'(m_i.m11);
    a22 = 35'(m_i.m22);
    tr = a00 + a11 + a22;
    c_o = '0;
    if (tr > 0) begin
      rr = tr + One;
      c_o.big = AxisW; c_o.o1 = AxisX; c_o.o2 = AxisY; c_o.o3 = AxisZ;
      c_o.d1 = 18'(35'(m_i.m12) - 35'(m_i.m21));
      c_o.d2 = 18'(35'(m_i.m20) - 35'(m_i.m02));
      c_o.d3 = 18'(35'(m_i.m01) - 35'(m_i.m10));
      dii = '0; djj = '0; dkk = '0; ai = 2'd0;
    end else begin
      ai = 2'd0;
      if (a11 > a00) ai = 2'd1;
      if (a22 > ((ai == 2'd1) ? a11 : a00)) ai = 2'd2;
      case (ai)
        2'd1: begin dii = a11; djj = a22; dkk = a00; end
        2'd2: begin dii = a22; djj = a00; dkk = a11; end
        default: begin dii = a00; djj = a11; dkk = a22; end
      endcase
      rr = dii - (djj + dkk) + One;
      c_o.o1 = AxisW;
      case (ai)
        2'd1: begin
          c_o.big = AxisY; c_o.o2 = AxisZ; c_o.o3 = AxisX;
          c_o.d1 = 18'(35'(m_i.m20) - 35'(m_i.m02));
          c_o.d2 = 18'(35'(m_i.m12) + 35'(m_i.m21));
          c_o.d3 = 18'(35'(m_i.m10) + 35'(m_i.m01));
        end
        2'd2: begin
          c_o.big = AxisZ; c_o.o2 = AxisX; c_o.o3 = AxisY;
          c_o.d1 = 18'(35'(m_i.m01) - 35'(m_i.m10));
          c_o.d2 = 18'(35'(m_i.m20) + 35'(m_i.m02));
          c_o.d3 = 18'(35'(m_i.m21) + 35'(m_i.m12));
        end
        default: begin
          c_o.big = AxisX; c_o.o2 = AxisY; c_o.o3 = AxisZ;
          c_o.d1 = 18'(35'(m_i.m12) - 35'(m_i.m21));
          c_o.d2 = 18'(35'(m_i.m01) + 35'(m_i.m10));
          c_o.d3 = 18'(35'(m_i.m02) + 35'(m_i.m20));
        end
      endcase
      if (rr <= 0) c_o.degen = 1'b1;
    end
    c_o.r = (rr > 0) ? rr[RW-1:0] : '0;
  end
endmodule
`default_nettype wire

// ===== hdl/rmq_back.sv =====
// rmq_back: pipelined square root and three pipelined dividers with rounding, saturation.
// Depends on rmq_pkg.
`default_nettype none
module rmq_back #(
  parameter int unsigned FracBits = rmq_pkg::FracBitsDef
) (
  input  var logic          clk_i,
  input  var logic          rst_ni,
  input  var logic          v_i,
  input  var rmq_pkg::cls_t c_i,
  output logic              v_o,
  output rmq_pkg::quat_t    q_o
);
  import rmq_pkg::*;
  localparam int unsigned SqW = RW + FracBits;       // radicand width
  localparam int unsigned SqN = (SqW + 1) / 2;        // root bits / stages
  localparam int unsigned NumW = 17 + FracBits + 1;   // |d|<<F plus S
  localparam int unsigned DenW = SqN + 1;
  localparam int unsigned Lat = SqN + NumW + 1;

  // sqrt pipeline: one root bit per stage
  logic [SqN-1:0]  sroot_q [SqN+1];
  logic [2*SqN-1:0] srem_q [SqN+1];
  logic [2*SqN-1:0] srad_q [SqN+1];
  logic [Lat:0]    v_q;
  cls_t            cp_q [Lat+1];
  // divider pipeline
  logic [NumW-1:0] nm_q [3][NumW+1];
  logic [NumW-1:0] rm_q [3][NumW+1];
  logic [NumW-1:0] qu_q [3][NumW+1];
  logic [DenW-1:0] dn_q [NumW+1];
  logic [2:0]      sg_q [NumW+1];
  logic [SqN-1:0]  sh_q [NumW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[Lat-1:0], v_i};
    end
  end

  always_ff @(posedge clk_i) begin
    cp_q[0] <= c_i;
    sroot_q[0] <= '0;
    srem_q[0] <= '0;
    srad_q[0] <= (2*SqN)'({c_i.r, FracBits'(0)});
    for (int i = 1; i <= Lat; i++) cp_q[i] <= cp_q[i-1];
  end

  for (genvar g = 0; g < SqN; g++) begin : g_sq
    logic [2*SqN-1:0] rem, trial;
    always_comb begin
      rem = {srem_q[g][2*SqN-3:0], srad_q[g][2*SqN-1 -: 2]};
      trial = (2*SqN)'({sroot_q[g], 2'b01});
    end
    always_ff @(posedge clk_i) begin
      srad_q[g+1] <= srad_q[g] << 2;
      if (rem >= trial) begin
        srem_q[g+1] <= rem - trial;
        sroot_q[g+1] <= {sroot_q[g][SqN-2:0], 1'b1};
      end else begin
        srem_q[g+1] <= rem;
        sroot_q[g+1] <= {sroot_q[g][SqN-2:0], 1'b0};
      end
    end
  end

  logic [SqN-1:0] sres;
  logic signed [17:0] dd [3];
  assign sres = sroot_q[SqN];
  always_comb begin
    dd[0] = cp_q[SqN].d1;
    dd[1] = cp_q[SqN].d2;
    dd[2] = cp_q[SqN].d3;
  end

  always_ff @(posedge clk_i) begin
    dn_q[0] <= {sres, 1'b0};
    sh_q[0] <= sres;
    for (int k = 0; k < 3; k++) begin
      sg_q[0][k] <= dd[k][17];
      nm_q[k][0] <= NumW'({(dd[k][17] ? 18'(-dd[k]) : dd[k]), FracBits'(0)}) + NumW'(sres);
      rm_q[k][0] <= '0;
      qu_q[k][0] <= '0;
    end
    for (int i = 1; i <= NumW; i++) begin
      dn_q[i] <= dn_q[i-1];
      sg_q[i] <= sg_q[i-1];
      sh_q[i] <= sh_q[i-1];
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_dv
    for (genvar g = 0; g < NumW; g++) begin : g_st
      logic [NumW:0] rr;
      assign rr = {rm_q[k][g], nm_q[k][g][NumW-1]};
      always_ff @(posedge clk_i) begin
        nm_q[k][g+1] <= nm_q[k][g] << 1;
        if (rr >= (NumW+1)'(dn_q[g])) begin
          rm_q[k][g+1] <= NumW'(rr - (NumW+1)'(dn_q[g]));
          qu_q[k][g+1] <= {qu_q[k][g][NumW-2:0], 1'b1};
        end else begin
          rm_q[k][g+1] <= NumW'(rr);
          qu_q[k][g+1] <= {qu_q[k][g][NumW-2:0], 1'b0};
        end
      end
    end
  end

  logic signed [63:0] comp [4];
  logic signed [63:0] qv;
  cls_t ce;
  always_comb begin
    ce = cp_q[Lat];
    for (int j = 0; j < 4; j++) comp[j] = '0;
    comp[ce.big] = 64'(sh_q[NumW] >> 1);
    for (int k = 0; k < 3; k++) begin
      qv = 64'(qu_q[k][NumW]);
      if (sg_q[NumW][k]) qv = -qv;
      case (k)
        0: comp[ce.o1] = qv;
        1: comp[ce.o2] = qv;
        default: comp[ce.o3] = qv;
      endcase
    end
    if (ce.degen) begin
      comp[0] = '0; comp[1] = '0; comp[2] = '0;
      comp[3] = 64'sd1 <<< FracBits;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_o <= 1'b0;
    else v_o <= v_q[Lat];
  end
  always_ff @(posedge clk_i) begin
    q_o.qx <= sat16(comp[0]);
    q_o.qy <= sat16(comp[1]);
    q_o.qz <= sat16(comp[2]);
    q_o.qw <= sat16(comp[3]);
    q_o.degenerate <= ce.degen;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) v_o |-> $past(v_q[Lat]))
    else $error("strobe without pipeline item");
  assert property (@(posedge clk_i) disable iff (!rst_ni) v_o && q_o.degenerate |->
    q_o.qx == 0 && q_o.qy == 0 && q_o.qz == 0) else $error("degenerate not identity");
  assert property (@(posedge clk_i) disable iff (!rst_ni) v_q[SqN] && !cp_q[SqN].degen
    |-> sres != 0) else $error("zero root");
endmodule
`default_nettype wire

// ===== hdl/rmq_fifo.sv =====
// rmq_fifo: short queue of classified items between front and back.
// Depends on rmq_pkg.
`default_nettype none
module rmq_fifo (
  input  var logic          clk_i,
  input  var logic          rst_ni,
  input  var logic          push_i,
  input  var rmq_pkg::cls_t d_i,
  output logic              full_o,
  output logic              pop_o,
  output rmq_pkg::cls_t     d_o
);
  import rmq_pkg::*;
  localparam int unsigned AW = $clog2(QDepth);
  cls_t mem_q [QDepth];
  logic [AW-1:0] wp_q, rp_q;
  logic [AW:0] cnt_q;
  // back never stalls: pop whenever not empty
  assign pop_o = cnt_q != 0;
  assign full_o = cnt_q == (AW+1)'(QDepth);
  assign d_o = mem_q[rp_q];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + 1'b1;
      if (pop_o) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (AW+1)'(push_i) - (AW+1)'(pop_o);
    end
  end
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= d_i;
  end
endmodule
`default_nettype wire

// ===== hdl/rotation_matrix_to_quaternion.sv =====
// rotation_matrix_to_quaternion: top level, front classifier, queue, root/divide back end.
// Depends on rmq_pkg, rmq_front, rmq_fifo, rmq_back.
//
// Usage: drive mat_i and raise start; the item is taken on an edge where busy is low.
// busy only rises if the internal queue fills, which does not happen since the back
// end accepts one item per cycle; a new item may be given every cycle.
// Each item yields one result on quat_o, marked by done_o for exactly one cycle.
// Path from the accepting edge to done_o: the queue, the root pipeline input register,
// the root stages (one root bit per stage), one divider input register,
// 18+FRAC_BITS divider stages and the output register; throughput one item per cycle.
// The receiver cannot stall; results are never held.
// Reset clears all valid flags and the queue; items in flight are dropped.
`default_nettype none
module rotation_matrix_to_quaternion #(
  parameter int unsigned FRAC_BITS = rmq_pkg::FracBitsDef
) (
  input  var logic           clk_i,
  input  var logic           rst_ni,
  input  var logic           start,
  output logic               busy,
  input  var rmq_pkg::mat_t  mat_i,
  output logic               done_o,
  output rmq_pkg::quat_t     quat_o
);
  import rmq_pkg::*;
  cls_t cf, cq;
  logic full, pop;
  rmq_front #(.FracBits(FRAC_BITS)) u_front (.m_i(mat_i), .c_o(cf));
  rmq_fifo u_fifo (.clk_i, .rst_ni, .push_i(start && !busy), .d_i(cf),
    .full_o(full), .pop_o(pop), .d_o(cq));
  assign busy = full;
  rmq_back #(.FracBits(FRAC_BITS)) u_back (.clk_i, .rst_ni, .v_i(pop), .c_i(cq),
    .v_o(done_o), .q_o(quat_o));
endmodule
`default_nettype wire
